// File: rtl/pbi_pkg.sv
// Shared types, codes and constants of the palette builder and indexer.
package pbi_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 256;
	localparam int PIXEL_W = 24;

	localparam logic FMT_RGB555 = 1'b0;
	localparam logic FMT_RGB888 = 1'b1;

	localparam logic [1:0] DEPTH_1BIT = 2'd0;
	localparam logic [1:0] DEPTH_4BIT = 2'd1;
	localparam logic [1:0] DEPTH_8BIT = 2'd2;

	typedef enum logic [1:0] {
		KIND_LEARN = 2'd0,
		KIND_MAP   = 2'd1,
		KIND_READ  = 2'd2,
		KIND_CLEAR = 2'd3
	} pbi_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FETCH,
		ST_DONE
	} pbi_state_t;

	typedef struct packed {
		pbi_kind_t            kind;
		logic [PIXEL_W-1:0]   pixel;
		logic [7:0]           entry_index;
	} pbi_item_t;

	typedef struct packed {
		logic [7:0] color_index;
		logic       found;
		logic [8:0] color_count;
		logic       overflow;
		logic [1:0] target_depth;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pbi_result_t;

	// Result of the engine before the color expansion of the output stage.
	typedef struct packed {
		logic [7:0]         color_index;
		logic               found;
		logic [8:0]         color_count;
		logic               overflow;
		logic [1:0]         target_depth;
		logic [PIXEL_W-1:0] entry;
	} pbi_raw_t;

	// 255 * v / 31, truncated, for every 5-bit value v.
	localparam logic [7:0] EXPAND5 [32] = '{
		8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
		8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
		8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
		8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
	};

endpackage

// File: rtl/pbi_chan_if.sv
// Valid/ready channel carrying one payload of a configurable type.
interface pbi_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/pbi_engine.sv
// Search sequencer around the color table memory, with count and overflow state.
module pbi_engine
	import pbi_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pixel_format,
	pbi_chan_if.sink   items,
	pbi_chan_if.source raw
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int XW = (CW > 8) ? CW : 8;

	logic [PIXEL_W-1:0] mem [TABLE_DEPTH];

	pbi_state_t         state_q, state_d;
	pbi_kind_t          kind_q;
	logic [PIXEL_W-1:0] key_q;
	logic [CW-1:0]      ptr_q;
	logic               pend_q;
	logic [AW-1:0]      cmp_idx_q;
	logic [PIXEL_W-1:0] rd_data_q;
	logic [CW-1:0]      count_q;
	logic               ovf_q;
	logic               rd_ok_q;
	logic [7:0]         res_idx_q;
	logic               res_hit_q;
	logic [PIXEL_W-1:0] res_entry_q;

	logic               accept;
	logic [PIXEL_W-1:0] key_in;
	logic               match;
	logic               scan_end;
	logic               full;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic               search_rd;

	assign accept = items.valid & items.ready;
	assign key_in = (pixel_format == FMT_RGB555) ?
		{{(PIXEL_W-15){1'b0}}, items.data.pixel[14:0]} : items.data.pixel;
	assign match    = pend_q && (rd_data_q == key_q);
	assign scan_end = !pend_q && (ptr_q >= count_q);
	assign full     = (count_q == CW'(TABLE_DEPTH));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (items.data.kind) inside
						KIND_LEARN, KIND_MAP: state_d = ST_SEARCH;
						KIND_READ:            state_d = ST_FETCH;
						KIND_CLEAR:           state_d = ST_DONE;
						default:              state_d = ST_DONE;
					endcase
				end
			end
			ST_SEARCH: begin
				if (match || scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_FETCH: state_d = ST_DONE;
			ST_DONE: begin
				if (raw.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		items.ready = 1'b0;
		raw.valid   = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = ptr_q[AW-1:0];
		wr_en       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				items.ready = 1'b1;
				if (accept && items.data.kind == KIND_READ) begin
					rd_en   = 1'b1;
					rd_addr = AW'(items.data.entry_index);
				end
			end
			ST_SEARCH: begin
				rd_en = !match && (ptr_q < count_q);
				wr_en = scan_end && (kind_q == KIND_LEARN) && !full;
			end
			ST_FETCH: begin
			end
			ST_DONE: raw.valid = 1'b1;
			default: begin
			end
		endcase
	end

	assign search_rd = (state_q == ST_SEARCH) && rd_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= search_rd;
			if (accept && items.data.kind == KIND_CLEAR) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (state_q == ST_SEARCH && scan_end && kind_q == KIND_LEARN) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= key_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q      <= items.data.kind;
			key_q       <= key_in;
			ptr_q       <= '0;
			rd_ok_q     <= XW'(items.data.entry_index) < XW'(count_q);
			res_idx_q   <= (items.data.kind == KIND_READ) ? items.data.entry_index : 8'd0;
			res_hit_q   <= 1'b0;
			res_entry_q <= '0;
		end
		if (search_rd) begin
			ptr_q     <= ptr_q + CW'(1);
			cmp_idx_q <= ptr_q[AW-1:0];
		end
		if (state_q == ST_SEARCH) begin
			if (match) begin
				res_idx_q   <= 8'(cmp_idx_q);
				res_hit_q   <= 1'b1;
				res_entry_q <= rd_data_q;
			end else if (scan_end && kind_q == KIND_LEARN && !full) begin
				// A new color takes the next free entry.
				res_idx_q   <= 8'(count_q);
				res_hit_q   <= 1'b1;
				res_entry_q <= key_q;
			end
		end
		if (state_q == ST_FETCH) begin
			res_hit_q   <= rd_ok_q;
			res_entry_q <= rd_ok_q ? rd_data_q : '0;
		end
	end

	always_comb begin
		raw.data.color_index = res_idx_q;
		raw.data.found       = res_hit_q;
		raw.data.color_count = 9'(count_q);
		raw.data.overflow    = ovf_q;
		raw.data.entry       = res_entry_q;
		if (32'(count_q) <= 32'd2) begin
			raw.data.target_depth = DEPTH_1BIT;
		end else if (32'(count_q) <= 32'd16) begin
			raw.data.target_depth = DEPTH_4BIT;
		end else begin
			raw.data.target_depth = DEPTH_8BIT;
		end
	end

endmodule

// File: rtl/pbi_result_stage.sv
// Output register that expands the table entry into 8-bit red, green and blue.
module pbi_result_stage
	import pbi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pixel_format,
	pbi_chan_if.sink   raw,
	pbi_chan_if.source results
);

	logic        full_q;
	pbi_result_t out_q;
	pbi_result_t conv;
	logic        load;

	assign raw.ready = !full_q || results.ready;
	assign load      = raw.valid && raw.ready;

	always_comb begin
		conv.color_index  = raw.data.color_index;
		conv.found        = raw.data.found;
		conv.color_count  = raw.data.color_count;
		conv.overflow     = raw.data.overflow;
		conv.target_depth = raw.data.target_depth;
		conv.red          = 8'd0;
		conv.green        = 8'd0;
		conv.blue         = 8'd0;
		if (raw.data.found) begin
			if (pixel_format == FMT_RGB555) begin
				conv.red   = EXPAND5[raw.data.entry[14:10]];
				conv.green = EXPAND5[raw.data.entry[9:5]];
				conv.blue  = EXPAND5[raw.data.entry[4:0]];
			end else begin
				conv.red   = raw.data.entry[23:16];
				conv.green = raw.data.entry[15:8];
				conv.blue  = raw.data.entry[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else begin
			full_q <= load || (full_q && !results.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= conv;
		end
	end

	assign results.valid = full_q;
	assign results.data  = out_q;

endmodule

// File: rtl/palette_builder_and_indexer.sv
// Top level of the palette builder and indexer.
//
//   channel   dir  payload        transfer when
//   items     in   pbi_item_t     items.valid & items.ready
//   results   out  pbi_result_t   results.valid & results.ready
//   cfg       in   pixel_format   cfg.valid & cfg.ready (always ready)
//
// One item is worked at a time. A learn or map item scans the table memory one entry
// per cycle until it finds the color or has compared every stored entry.
// The output register holds a finished result, so the next item is taken while it waits.
// Reset empties the table and clears the overflow flag; pixel format resets to 24-bit RGB.
module palette_builder_and_indexer
	import pbi_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	pbi_chan_if.sink   items,
	pbi_chan_if.sink   cfg,
	pbi_chan_if.source results
);

	logic fmt_q;

	pbi_chan_if #(.T(pbi_raw_t)) raw_ch ();

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RGB888;
		end else if (cfg.valid && cfg.ready) begin
			fmt_q <= cfg.data;
		end
	end

	pbi_engine #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_format(fmt_q),
		.items       (items),
		.raw         (raw_ch)
	);

	pbi_result_stage u_result (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_format(fmt_q),
		.raw         (raw_ch),
		.results     (results)
	);

endmodule

// File: rtl/pbi_checker.sv
// Port-level checks of the palette builder and indexer, bound to the top level.
module pbi_checker
	import pbi_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_found,
	input logic [8:0] out_count,
	input logic [1:0] out_depth,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue
);

	logic [1:0] pending_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// Items taken but whose result has not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (in_xfer && !out_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_xfer && !in_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before its transfer");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result shown with no item outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more items in flight than the block can hold");

	a_miss_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_found |-> out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
		else $error("color shown for an entry that was not found");

	a_depth_small: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_depth == DEPTH_1BIT |-> out_count <= 9'd2)
		else $error("one-bit depth reported for more than two colors");

endmodule

bind palette_builder_and_indexer pbi_checker u_pbi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (items.valid),
	.in_ready (items.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_found(results.data.found),
	.out_count(results.data.color_count),
	.out_depth(results.data.target_depth),
	.out_red  (results.data.red),
	.out_green(results.data.green),
	.out_blue (results.data.blue)
);
